FILE: sv/mlp_pkg.sv
// Shared types, constants and helpers for the minimum-capacity partition block.
// No dependencies; every other file imports this package.
package mlp_pkg;

  localparam int WEIGHT_W          = 16;   // input weight field
  localparam int CAP_W             = 26;   // result capacity field
  localparam int DAYS_W            = 11;   // max_days register
  localparam int MAX_PACKAGES_DEF  = 1024;
  localparam int WEIGHT_BITS_DEF   = 16;

  localparam logic [CAP_W-1:0] CAP_MAX = {CAP_W{1'b1}};

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIV,
    ST_CHECK,
    ST_SCAN,
    ST_DONE
  } mlp_state_t;

  // status of the greedy day-count pass
  typedef struct packed {
    logic busy;
    logic done;
  } mlp_scan_stat_t;

  function automatic int addr_w(input int depth);
    addr_w = (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

FILE: sv/mlp_if.sv
// Valid/ready channel interfaces for package weights and results.
// Depends on mlp_pkg for the field widths.
interface mlp_in_if import mlp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] weight;
  logic                last;

  modport source (output valid, output weight, output last, input ready);
  modport sink   (input valid, input weight, input last, output ready);
endinterface

interface mlp_out_if import mlp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;
  logic             overflow;

  modport source (output valid, output capacity, output overflow, input ready);
  modport sink   (input valid, input capacity, input overflow, output ready);
endinterface

FILE: sv/min_capacity_linear_partition.sv
// Minimum-capacity linear partition. Weights load into the store at one request per
// cycle. After the request flagged last, the block is busy (no input taken) for the
// bit-serial sum/max_days division, SUM_W = WEIGHT_BITS + clog2(MAX_PACKAGES+1) bits
// wide (27 at defaults), and then for a binary search of at most ceil(log2(sum -
// lower bound + 1)) probes; each probe is one full pass over the store through its
// single read port. Inputs are taken again once the result sits in the output
// register. max_days = 0 counts as 1; packages beyond the store size are dropped
// and flagged as overflow with that list.
// Depends on mlp_pkg, mlp_if, mlp_ram, mlp_div and mlp_scan.
module min_capacity_linear_partition import mlp_pkg::*; #(
  parameter int MAX_PACKAGES = MAX_PACKAGES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [DAYS_W-1:0] cfg_wdata,
  mlp_in_if.sink            in_if,
  mlp_out_if.source         out_if
);

  localparam int AW    = addr_w(MAX_PACKAGES);
  localparam int CNT_W = $clog2(MAX_PACKAGES + 1);
  localparam int SUM_W = WEIGHT_BITS + CNT_W;
  localparam int EXT_W = (SUM_W > CAP_W) ? SUM_W : CAP_W;

  mlp_state_t state_r, state_nxt;

  logic [DAYS_W-1:0]      max_days_r;
  logic [DAYS_W-1:0]      days_eff;
  logic [CNT_W-1:0]       cnt_r;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [WEIGHT_BITS-1:0] wmax_r;
  logic                   ovf_r;
  logic [SUM_W-1:0]       lo_r, hi_r, mid_r, mid_calc;
  logic [SUM_W:0]         lo_hi_sum;
  logic [SUM_W-1:0]       lo_init;

  logic                   out_valid_r;
  logic [CAP_W-1:0]       out_cap_r;
  logic                   out_ovf_r;

  logic [WEIGHT_BITS-1:0] w_in;
  logic                   in_ready;
  logic                   in_acc;
  logic                   full;
  logic                   store_we;
  logic                   scan_start;
  logic                   out_load;
  logic                   fits;
  logic [EXT_W-1:0]       lo_ext;
  logic [CAP_W-1:0]       cap_sat;

  logic                   div_done;
  logic [SUM_W-1:0]       div_q;

  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [WEIGHT_BITS-1:0] rd_data;
  mlp_scan_stat_t         scan_stat;
  logic [CNT_W-1:0]       scan_days;

  assign w_in     = WEIGHT_BITS'(in_if.weight);
  assign in_acc   = in_if.valid && in_ready;
  assign full     = (cnt_r == CNT_W'(MAX_PACKAGES));
  assign store_we = in_acc && !full;
  assign days_eff = (max_days_r == '0) ? DAYS_W'(1) : max_days_r;
  assign sum_nxt  = store_we ? sum_r + SUM_W'(w_in) : sum_r;

  assign lo_hi_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_calc  = lo_hi_sum[SUM_W:1];
  assign lo_init   = (div_q > SUM_W'(wmax_r)) ? div_q : SUM_W'(wmax_r);
  assign fits      = (32'(scan_days) <= 32'(days_eff));

  assign lo_ext  = EXT_W'(lo_r);
  assign cap_sat = (lo_ext > EXT_W'(CAP_MAX)) ? CAP_MAX : lo_ext[CAP_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:  if (in_acc && in_if.last) state_nxt = ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = (lo_r < hi_r) ? ST_SCAN : ST_DONE;
      ST_SCAN:  if (scan_stat.done) state_nxt = ST_CHECK;
      ST_DONE:  if (!out_valid_r || out_if.ready) state_nxt = ST_LOAD;
      default:  state_nxt = ST_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready   = 1'b0;
    scan_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_LOAD:  in_ready = 1'b1;
      ST_DIV:   ;
      ST_CHECK: scan_start = (lo_r < hi_r);
      ST_SCAN:  ;
      ST_DONE:  out_load = !out_valid_r || out_if.ready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      max_days_r  <= DAYS_W'(1);
      cnt_r       <= '0;
      sum_r       <= '0;
      wmax_r      <= '0;
      ovf_r       <= 1'b0;
      lo_r        <= '0;
      hi_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        max_days_r <= cfg_wdata;
      end
      if (in_acc) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
          sum_r <= sum_nxt;
          if (w_in > wmax_r) begin
            wmax_r <= w_in;
          end
        end
      end
      if (state_r == ST_DIV && div_done) begin
        lo_r <= lo_init;
        hi_r <= sum_r;
      end
      if (state_r == ST_SCAN && scan_stat.done) begin
        if (fits) begin
          hi_r <= mid_r;
        end else begin
          lo_r <= mid_r + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        cnt_r       <= '0;
        sum_r       <= '0;
        wmax_r      <= '0;
        ovf_r       <= 1'b0;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      mid_r <= mid_calc;
    end
    if (out_load) begin
      out_cap_r <= cap_sat;
      out_ovf_r <= ovf_r;
    end
  end

  assign in_if.ready     = in_ready;
  assign out_if.valid    = out_valid_r;
  assign out_if.capacity = out_cap_r;
  assign out_if.overflow = out_ovf_r;

  mlp_ram #(
    .DATA_W (WEIGHT_BITS),
    .DEPTH  (MAX_PACKAGES)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (w_in),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  mlp_div #(
    .N_W (SUM_W),
    .D_W (DAYS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc && in_if.last),
    .dividend (sum_nxt),
    .divisor  (days_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  mlp_scan #(
    .AW          (AW),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .cap     (mid_calc),
    .count   (cnt_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .stat    (scan_stat),
    .days    (scan_days)
  );

  // overflow can only be flagged once the store is full
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> full)
    else $error("overflow flag set with store not full");

  a_last_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_if.last) |=> (state_r == ST_DIV))
    else $error("last request did not start the search");

  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (lo_r < hi_r) && (mid_r >= lo_r) && (mid_r < hi_r))
    else $error("search probe outside bounds");

  a_scan_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_SCAN) |-> !scan_stat.busy)
    else $error("store pass running outside search");

  a_no_input_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_stat.busy || state_r == ST_DIV) |-> !in_ready)
    else $error("input accepted during search");

endmodule

FILE: sv/mlp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on mlp_pkg for the address width helper.
module mlp_ram import mlp_pkg::*; #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 1024,
  localparam int ADDR_W = addr_w(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/mlp_div.sv
// Restoring divider, one quotient bit per cycle; quotient only.
// Depends on mlp_pkg (imported for house consistency).
module mlp_div import mlp_pkg::*; #(
  parameter int N_W = 27,
  parameter int D_W = DAYS_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [N_W-1:0] quotient
);

  localparam int CW = $clog2(N_W + 1);

  logic [N_W-1:0] q_r, q_nxt;
  logic [D_W-1:0] rem_r, rem_nxt;
  logic [D_W-1:0] d_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [D_W:0]   trial;
  logic           qbit;

  always_comb begin
    trial = {rem_r, q_r[N_W-1]};
    qbit  = (trial >= {1'b0, d_r});
    rem_nxt = qbit ? D_W'(trial - {1'b0, d_r}) : trial[D_W-1:0];
    q_nxt   = {q_r[N_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(N_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: sv/mlp_scan.sv
// Greedy day-count pass: streams stored weights out of the RAM for one capacity.
// Depends on mlp_pkg for the status struct.
module mlp_scan import mlp_pkg::*; #(
  parameter int AW          = 10,
  parameter int CNT_W       = 11,
  parameter int SUM_W       = 27,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [SUM_W-1:0]       cap,
  input  logic [CNT_W-1:0]       count,
  output logic                   rd_en,
  output logic [AW-1:0]          rd_addr,
  input  logic [WEIGHT_BITS-1:0] rd_data,
  output mlp_scan_stat_t         stat,
  output logic [CNT_W-1:0]       days
);

  logic             issue_r, pend_r, done_r;
  logic [CNT_W-1:0] idx_r;
  logic [SUM_W-1:0] cap_r;
  logic [SUM_W-1:0] load_r, load_nxt;
  logic [CNT_W-1:0] days_r, days_nxt;
  logic [SUM_W:0]   acc;

  always_comb begin
    acc = {1'b0, load_r} + (SUM_W + 1)'(rd_data);
    if (acc > {1'b0, cap_r}) begin
      // package opens a new day
      days_nxt = days_r + 1'b1;
      load_nxt = SUM_W'(rd_data);
    end else begin
      days_nxt = days_r;
      load_nxt = acc[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
      pend_r  <= 1'b0;
      done_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      pend_r <= issue_r;
      done_r <= pend_r && !issue_r;
      if (start) begin
        issue_r <= 1'b1;
        idx_r   <= '0;
      end else if (issue_r) begin
        idx_r <= idx_r + 1'b1;
        if (idx_r + 1'b1 == count) begin
          issue_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cap_r  <= cap;
      load_r <= '0;
      days_r <= CNT_W'(1);
    end else if (pend_r) begin
      load_r <= load_nxt;
      days_r <= days_nxt;
    end
  end

  assign rd_en     = issue_r;
  assign rd_addr   = idx_r[AW-1:0];
  assign stat.busy = issue_r || pend_r;
  assign stat.done = done_r;
  assign days      = days_r;

endmodule

FILE: sim/min_capacity_linear_partition_test.sv
// Self-checking testbench for min_capacity_linear_partition: weight lists in, minimum
// ship capacity and overflow flag out, checked against an in-bench capacity search.
// Depends on mlp_pkg, mlp_if and the block's RTL.
`timescale 1ns / 1ps

module min_capacity_linear_partition_test;
  import mlp_pkg::*;

  localparam int STORE_DEPTH = MAX_PACKAGES_DEF;
  localparam int SMALL_LIST_ITEMS = 320;   // requests sent, plan rows included, before the long list
  localparam int HOLD_CYCLES = 4000;
  localparam int HOLD_AFTER = 12;          // results seen before the long receiver hold
  localparam int QUIET_LIMIT = 150000;     // idle cycles tolerated before the run ends in error
  localparam int TAIL_CYCLES = 64;

  typedef struct packed {
    logic [CAP_W-1:0] capacity;
    logic             overflow;
  } result_t;

  typedef struct packed {
    logic             typed;
    logic [CAP_W-1:0] capacity;
    logic             overflow;
  } pinned_t;

  typedef struct packed {
    logic                wr;
    logic [DAYS_W-1:0]   days;
    logic [WEIGHT_W-1:0] weight;
    logic                last;
    logic                typed;
    logic [CAP_W-1:0]    capacity;
  } step_t;

  // wr, days, weight, last, typed, capacity
  localparam step_t PLAN [25] = '{
    // reset day limit of one: capacity is the plain sum
    '{1'b0, 11'd0,    16'd5,      1'b0, 1'b0, 26'd0},
    '{1'b0, 11'd0,    16'd7,      1'b1, 1'b1, 26'd12},
    '{1'b1, 11'd2047, 16'hFFFF,   1'b1, 1'b1, 26'd65535},
    // zero day limit: a single zero weight, then a list whose capacity is its plain sum
    '{1'b1, 11'd0,    16'd0,      1'b1, 1'b1, 26'd0},
    '{1'b0, 11'd0,    16'hFFFF,   1'b0, 1'b0, 26'd0},
    '{1'b0, 11'd0,    16'hFFFF,   1'b0, 1'b0, 26'd0},
    '{1'b0, 11'd0,    16'd0,      1'b0, 1'b0, 26'd0},
    '{1'b0, 11'd0,    16'd1,      1'b1, 1'b1, 26'd131071},
    // more days than packages: capacity is the largest weight; later lists use the in-bench search
    '{1'b1, 11'd1024, 16'd3,      1'b0, 1'b0, 26'd0},
    '{1'b0, 11'd0,    16'd9,      1'b0, 1'b0, 26'd0},
    '{1'b0, 11'd0,    16'd4,      1'b1, 1'b1, 26'd9},
    '{1'b1, 11'd2,    16'd1,      1'b0, 1'b0, 26'd0},
    '{1'b0, 11'd0,    16'd2,      1'b0, 1'b0, 26'd0},
    '{1'b0, 11'd0,    16'd3,      1'b0, 1'b0, 26'd0},
    '{1'b0, 11'd0,    16'd4,      1'b0, 1'b0, 26'd0},
    '{1'b0, 11'd0,    16'd5,      1'b1, 1'b0, 26'd0},
    '{1'b1, 11'd3,    16'd7,      1'b0, 1'b0, 26'd0},
    '{1'b0, 11'd0,    16'd2,      1'b0, 1'b0, 26'd0},
    '{1'b0, 11'd0,    16'd5,      1'b0, 1'b0, 26'd0},
    '{1'b0, 11'd0,    16'd10,     1'b0, 1'b0, 26'd0},
    '{1'b0, 11'd0,    16'd8,      1'b1, 1'b0, 26'd0},
    '{1'b1, 11'd2,    16'd0,      1'b0, 1'b0, 26'd0},
    '{1'b0, 11'd0,    16'd0,      1'b0, 1'b0, 26'd0},
    '{1'b0, 11'd0,    16'd6,      1'b0, 1'b0, 26'd0},
    '{1'b0, 11'd0,    16'd0,      1'b1, 1'b0, 26'd0}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [DAYS_W-1:0] cfg_wdata;

  mlp_in_if  in_ch ();
  mlp_out_if out_ch ();

  min_capacity_linear_partition uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [DAYS_W-1:0]   ship_days;
  logic [WEIGHT_W-1:0] list_weights[$];
  logic                list_overflow;
  result_t             expected_results[$];
  pinned_t             typed_results[$];

  int mismatches = 0;
  int results_seen = 0;
  int packages_sent = 0;
  int burst_left = 0;
  int quiet_cycles = 0;
  bit hold_active = 0;
  bit hold_done = 0;
  logic [7:0] stall_pattern = 8'b1011_0010;

  // smallest capacity that ships list_weights in at most ship_days greedy groups
  function automatic logic [CAP_W-1:0] min_capacity();
    longint unsigned d, total, peak, lo, hi, mid, load, groups;
    d = (ship_days == '0) ? 1 : ship_days;
    total = 0;
    peak = 0;
    foreach (list_weights[i]) begin
      total += list_weights[i];
      if (list_weights[i] > peak) peak = list_weights[i];
    end
    lo = total / d;
    if (peak > lo) lo = peak;
    hi = total;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      load = 0;
      groups = 1;
      foreach (list_weights[i]) begin
        load += list_weights[i];
        if (load > mid) begin
          groups++;
          load = list_weights[i];
        end
      end
      if (groups <= d) hi = mid;
      else lo = mid + 1;
    end
    if (lo > CAP_MAX) lo = CAP_MAX;
    return lo[CAP_W-1:0];
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return WEIGHT_W'($urandom_range(1, 15));
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  // input side: track the list, predict on the last request
  always @(posedge clk) begin
    result_t exp_r;
    pinned_t pin;
    if (!rst_n) begin
      ship_days = 1;
      list_weights.delete();
      list_overflow = 1'b0;
    end else begin
      if (cfg_we) ship_days = cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        if (list_weights.size() < STORE_DEPTH) list_weights.push_back(in_ch.weight);
        else list_overflow = 1'b1;
        if (in_ch.last) begin
          exp_r.capacity = min_capacity();
          exp_r.overflow = list_overflow;
          if (typed_results.size() != 0) begin
            pin = typed_results.pop_front();
            if (pin.typed) begin
              exp_r.capacity = pin.capacity;
              exp_r.overflow = pin.overflow;
            end
          end
          expected_results.push_back(exp_r);
          list_weights.delete();
          list_overflow = 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result: capacity=%0d overflow=%0d", out_ch.capacity,
               out_ch.overflow);
        mismatches++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_ch.capacity !== exp_r.capacity) begin
          $error("capacity: expected %0d, got %0d", exp_r.capacity, out_ch.capacity);
          mismatches++;
        end
        if (out_ch.overflow !== exp_r.overflow) begin
          $error("overflow: expected %0d, got %0d", exp_r.overflow, out_ch.overflow);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stall modes, plus one long hold to back up the block
  initial begin
    int mode, span;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 120);
      repeat (span) begin
        @(posedge clk);
        if (!hold_done && results_seen >= HOLD_AFTER) begin
          hold_done = 1;
          hold_active = 1;
          out_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_active = 0;
        end
        stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= $urandom_range(0, 1);
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= stall_pattern[0];
        endcase
      end
    end
  end

  // one request; bursts end with a random gap
  task automatic send_package(input logic [WEIGHT_W-1:0] w, input logic l);
    int gap;
    in_ch.valid  <= 1'b1;
    in_ch.weight <= w;
    in_ch.last   <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    packages_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 60);
      gap = $urandom_range(1, 12);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // register write only once every result is out
  task automatic set_max_days(input logic [DAYS_W-1:0] days);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= days;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int n, list_no;
    logic [DAYS_W-1:0] days;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.weight <= '0;
    in_ch.last   <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < $size(PLAN); i++) begin
      if (PLAN[i].wr) set_max_days(PLAN[i].days);
      if (PLAN[i].last)
        typed_results.push_back(pinned_t'{PLAN[i].typed, PLAN[i].capacity, 1'b0});
      send_package(PLAN[i].weight, PLAN[i].last);
    end

    list_no = 0;
    while (packages_sent < SMALL_LIST_ITEMS) begin
      // skip reconfiguring during the long hold so requests keep coming
      if (list_no % 6 == 0 && !hold_active) begin
        case ($urandom_range(0, 5))
          0:       days = '0;
          1:       days = '1;
          2:       days = 11'd1;
          3:       days = 11'd1024;
          default: days = DAYS_W'($urandom_range(2, 12));
        endcase
        set_max_days(days);
      end
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      for (int k = 0; k < n; k++) send_package(pick_weight(), k == n - 1);
      list_no++;
    end

    // one list past the store size: the tail is dropped and flagged
    set_max_days(DAYS_W'($urandom_range(1, 4)));
    n = STORE_DEPTH + $urandom_range(1, 2);
    for (int k = 0; k < n; k++)
      send_package(($urandom_range(0, 1) != 0) ? 16'hFFFF : pick_weight(), k == n - 1);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: min_capacity_linear_partition.f
sv/mlp_pkg.sv
sv/mlp_if.sv
sv/mlp_ram.sv
sv/mlp_div.sv
sv/mlp_scan.sv
sv/min_capacity_linear_partition.sv
sim/min_capacity_linear_partition_test.sv
